FILE: design/first_fit_heap_allocator_core_macros.svh
// Assertion helpers
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH

`define FFHA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define FFHA_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: design/ffha_pkg.sv
`default_nettype none
package ffha_pkg;
  localparam int MAX_BLOCKS   = 256;
  localparam int HEADER_BYTES = 8;
  localparam int PAD_BYTES    = 4;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_NOMEM   = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] REG_HEAP_START = 2'd0;
  localparam logic [1:0] REG_HEAP_LIMIT = 2'd1;

  typedef struct packed {
    logic        act;
    logic        hit;
    logic [31:0] start;
    logic [22:0] len;
  } scan_t;

  typedef struct packed {
    logic              kind;
    logic [22:0]       size;
    logic [31:0]       addr;
    logic [CNT_W-1:0]  count;
    logic              we;
    logic [IDX_W-1:0]  widx;
    logic [31:0]       wstart;
  } query_t;
endpackage
`default_nettype wire

FILE: design/first_fit_heap_allocator_core.sv
// First-fit heap allocator. Each request beat (tuser: 0 allocate, 1 free)
// gives one result beat. A nonzero allocate or a free sends a search token
// down a row of MAX_BLOCKS table cells, one cell per cycle, so its result beat
// appears once the token has left the last cell, and the next request can be
// taken when that result beat is registered; an allocate of size zero skips
// the search and goes straight to its result. A new request is taken while the
// previous result still waits on the output; its own result then holds until
// the output is free. Blocks are never split or merged; heap_start also moves
// the bump pointer only while the table is empty.
`default_nettype none
`include "first_fit_heap_allocator_core_macros.svh"
module first_fit_heap_allocator_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,  // req_size[22:0], free_address[54:23]
  input  wire logic        s_tuser,  // req_type
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata   // result_status, payload_address, was_reused,
                                     // bytes_in_use
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]  state;
  logic [31:0] heap_limit;
  logic [31:0] bump_pointer;
  logic [31:0] used_bytes;
  logic [ffha_pkg::CNT_W-1:0] block_count;
  logic        kind;
  logic [22:0] size;
  logic [31:0] addr;
  logic        hit;
  logic [31:0] hit_start;
  logic [22:0] hit_len;
  logic        launch;
  logic        we;
  logic        fire;
  logic        room;
  logic [32:0] end_addr;
  logic [1:0]  res_status;
  logic [31:0] res_addr;
  logic        res_reused;
  logic [31:0] res_used;

  ffha_pkg::query_t q;
  ffha_pkg::scan_t  chain [0:ffha_pkg::MAX_BLOCKS];

  assign chain[0] = '{act: launch, hit: 1'b0, start: '0, len: '0};
  assign q = '{kind: kind, size: size, addr: addr, count: block_count, we: we,
               widx: block_count[ffha_pkg::IDX_W-1:0], wstart: bump_pointer};

  for (genvar i = 0; i < ffha_pkg::MAX_BLOCKS; i++) begin : g_cell
    ffha_cell u_cell (
      .clk(clk), .rst(rst), .idx(ffha_pkg::IDX_W'(i)), .q(q),
      .scan_in(chain[i]), .scan_out(chain[i+1])
    );
  end

  assign s_tready = (state == S_IDLE);
  assign end_addr = {1'b0, bump_pointer} + 33'(size) + 33'(ffha_pkg::HEADER_BYTES);
  assign room = (block_count < ffha_pkg::CNT_W'(ffha_pkg::MAX_BLOCKS))
             && (end_addr < {1'b0, heap_limit});
  assign fire = (state == S_FIN) && !(m_tvalid && !m_tready);
  assign we = fire && kind == ffha_pkg::REQ_ALLOC && size != '0 && !hit && room;

  always_comb begin
    res_status = ffha_pkg::ST_OK;
    res_addr   = '0;
    res_reused = 1'b0;
    res_used   = used_bytes;
    if (kind == ffha_pkg::REQ_FREE) begin
      if (hit) begin
        res_used = used_bytes - (32'(hit_len) + 32'(ffha_pkg::HEADER_BYTES));
      end else begin
        res_status = ffha_pkg::ST_UNKNOWN;
      end
    end else if (size == '0) begin
      res_status = ffha_pkg::ST_ZERO;
    end else if (hit) begin
      res_addr   = hit_start + 32'(ffha_pkg::HEADER_BYTES);
      res_reused = 1'b1;
      res_used   = used_bytes + 32'(size) + 32'(ffha_pkg::HEADER_BYTES);
    end else if (!room) begin
      res_status = ffha_pkg::ST_NOMEM;
    end else begin
      res_addr = bump_pointer + 32'(ffha_pkg::HEADER_BYTES);
      res_used = used_bytes + 32'(size)
               + 32'(ffha_pkg::HEADER_BYTES + ffha_pkg::PAD_BYTES);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      heap_limit   <= 32'd4063232;
      bump_pointer <= 32'd1048576;
      used_bytes   <= '0;
      block_count  <= '0;
      launch       <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      launch <= (state == S_IDLE) && s_tvalid
             && !(s_tuser == ffha_pkg::REQ_ALLOC && s_tdata[22:0] == '0);
      if (cfg_we && cfg_index == ffha_pkg::REG_HEAP_START && block_count == '0)
        bump_pointer <= cfg_data;
      if (cfg_we && cfg_index == ffha_pkg::REG_HEAP_LIMIT) heap_limit <= cfg_data;
      if (fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            kind <= s_tuser;
            size <= s_tdata[22:0];
            addr <= s_tdata[54:23];
            hit  <= 1'b0;
            if (s_tuser == ffha_pkg::REQ_ALLOC && s_tdata[22:0] == '0) begin
              state <= S_FIN;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (chain[ffha_pkg::MAX_BLOCKS].act) begin
            hit       <= chain[ffha_pkg::MAX_BLOCKS].hit;
            hit_start <= chain[ffha_pkg::MAX_BLOCKS].start;
            hit_len   <= chain[ffha_pkg::MAX_BLOCKS].len;
            state     <= S_FIN;
          end
        end
        S_FIN: begin
          if (fire) begin
            state      <= S_IDLE;
            m_tdata    <= {5'd0, res_used, res_reused, res_addr, res_status};
            used_bytes <= res_used;
            if (we) begin
              bump_pointer <= bump_pointer + 32'(size)
                            + 32'(ffha_pkg::HEADER_BYTES + ffha_pkg::PAD_BYTES);
              block_count  <= block_count + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `FFHA_ASSERT(a_count_max, block_count <= ffha_pkg::CNT_W'(ffha_pkg::MAX_BLOCKS), "table count overflow")
  `FFHA_ASSERT(a_token_in_scan, chain[ffha_pkg::MAX_BLOCKS].act |-> state == S_SCAN, "stray search token")
  `FFHA_ASSERT_NEXT(a_append_one, we, block_count == $past(block_count) + 1'b1, "append skipped count")
endmodule
`default_nettype wire

FILE: design/ffha_cell.sv
`default_nettype none
module ffha_cell (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [ffha_pkg::IDX_W-1:0] idx,
  input  wire ffha_pkg::query_t         q,
  input  wire ffha_pkg::scan_t          scan_in,
  output ffha_pkg::scan_t               scan_out
);
  logic [31:0] start;
  logic [22:0] len;
  logic        busy;
  logic        in_use;
  logic        fits;
  logic        match;

  assign in_use = {1'b0, idx} < q.count;
  assign fits = (q.kind == ffha_pkg::REQ_FREE)
              ? (start + 32'(ffha_pkg::HEADER_BYTES) == q.addr)
              : (!busy && len >= q.size);
  assign match = scan_in.act && !scan_in.hit && in_use && fits;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out.act <= 1'b0;
    end else begin
      scan_out.act <= scan_in.act;
    end
    scan_out.hit   <= scan_in.hit | match;
    scan_out.start <= match ? start : scan_in.start;
    scan_out.len   <= match ? len : scan_in.len;
    if (q.we && q.widx == idx) begin
      start <= q.wstart;
      len   <= q.size;
      busy  <= 1'b1;
    end else if (match) begin
      busy <= (q.kind == ffha_pkg::REQ_ALLOC);
    end
  end
endmodule
`default_nettype wire
